/* sv/mrf_pkg.sv */
// shared types and constants for the message ring fifo
`default_nettype none

package mrf_pkg;

	localparam int unsigned POOL_BYTES_DEF   = 16384;
	localparam int unsigned HEADER_BYTES_DEF = 8;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned LEN_W     = 14;
	localparam int unsigned FILL_W    = 14;
	localparam int unsigned OP_W      = 2;
	localparam int unsigned S_TDATA_W = 24;
	localparam int unsigned S_TUSER_W = 2;
	localparam int unsigned M_TDATA_W = 40;
	localparam int unsigned M_TUSER_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_SEND_START = 2'd0,
		OP_SEND_BYTE  = 2'd1,
		OP_RECV       = 2'd2
	} opcode_t;

	typedef struct packed {
		logic              accepted;
		logic [BYTE_W-1:0] data_byte;
		logic              first_of_message;
		logic              last_of_message;
		logic [LEN_W-1:0]  received_length;
		logic [FILL_W-1:0] fill_level;
	} res_t;

endpackage

`default_nettype wire

/* sv/message_ring_fifo_unit.sv */
// send byte, ignored opcode, refused send start or receive on empty ring: answered from idle
// accepted send start: two header byte writes through the ring write port
// receive inside a message: one ring read, result from the registered read data
// receive opening a message: two header reads, then one payload read unless the message is empty
// one word at a time; the next is taken the cycle after the last completes, if the queue has room
// reset: pointers, counters and flags clear asynchronously; ring contents are not cleared
`default_nettype none

module message_ring_fifo_unit
	import mrf_pkg::*;
#(
	parameter int unsigned POOL_BYTES   = POOL_BYTES_DEF,
	parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,   // payload_byte[7:0], message_length[21:8], zero pad
	input  wire logic [S_TUSER_W-1:0] s_tuser,   // opcode[1:0]
	// result stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,   // data_byte[7:0], received_length[21:8],
	                                             // fill_level[35:22], zero pad
	output logic                      m_tlast,   // last_of_message
	output logic      [M_TUSER_W-1:0] m_tuser    // accepted[0], first_of_message[1]
);

	localparam int unsigned PW = $clog2(POOL_BYTES);

	// memory interface between sequencer and ring
	logic              mem_we;
	logic [PW-1:0]     mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic [PW-1:0]     mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;

	// finished result from the sequencer
	logic res_valid;
	res_t res;

	// two-entry result queue: a word may wait at the output while the next one is worked on
	logic [1:0] cnt_q;
	res_t       e0_q;
	res_t       e1_q;
	logic       pop;
	logic       room;

	// only take a word when its result is sure to find a slot
	assign room = (cnt_q != 2'd2);
	assign pop  = m_tvalid && m_tready;

	mrf_ctrl #(
		.POOL_BYTES   (POOL_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.PW           (PW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.opcode         (opcode_t'(s_tuser[OP_W-1:0])),
		.payload_byte   (s_tdata[BYTE_W-1:0]),
		.message_length (s_tdata[BYTE_W+LEN_W-1:BYTE_W]),
		.room           (room),
		.res_valid      (res_valid),
		.res            (res),
		.mem_we         (mem_we),
		.mem_waddr      (mem_waddr),
		.mem_wdata      (mem_wdata),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata)
	);

	mrf_ring_ram #(
		.DEPTH (POOL_BYTES),
		.AW    (PW)
	) u_ring (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, res_valid} - {1'b0, pop};
		end
	end

	// queue payload, head in e0
	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2) begin
				e0_q <= e1_q;
			end else if (res_valid) begin
				e0_q <= res;
			end
		end else if (res_valid && (cnt_q == 2'd0)) begin
			e0_q <= res;
		end
		if (res_valid && (((cnt_q == 2'd1) && !pop) || ((cnt_q == 2'd2) && pop))) begin
			e1_q <= res;
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {{(M_TDATA_W-BYTE_W-LEN_W-FILL_W){1'b0}},
	                   e0_q.fill_level, e0_q.received_length, e0_q.data_byte};
	assign m_tlast  = e0_q.last_of_message;
	assign m_tuser  = {e0_q.first_of_message, e0_q.accepted};

endmodule

`default_nettype wire

/* sv/mrf_ring_ram.sv */
// byte ring storage: one write port, one read port with registered data
`default_nettype none

module mrf_ring_ram
	import mrf_pkg::*;
#(
	parameter int unsigned DEPTH = POOL_BYTES_DEF,
	parameter int unsigned AW    = $clog2(POOL_BYTES_DEF)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [BYTE_W-1:0] wdata,
	input  wire logic [AW-1:0]     raddr,
	output logic      [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	assign rdata = rd_data_q;

endmodule

`default_nettype wire

/* sv/mrf_ctrl.sv */
// pointer state and item sequencer around the byte ring
`default_nettype none

module mrf_ctrl
	import mrf_pkg::*;
#(
	parameter int unsigned POOL_BYTES   = POOL_BYTES_DEF,
	parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int unsigned PW           = $clog2(POOL_BYTES_DEF)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire opcode_t           opcode,
	input  wire logic [BYTE_W-1:0] payload_byte,
	input  wire logic [LEN_W-1:0]  message_length,
	input  wire logic              room,
	output logic                   res_valid,
	output res_t                   res,
	output logic                   mem_we,
	output logic      [PW-1:0]     mem_waddr,
	output logic      [BYTE_W-1:0] mem_wdata,
	output logic      [PW-1:0]     mem_raddr,
	input  wire logic [BYTE_W-1:0] mem_rdata
);

	localparam int unsigned NW = ((PW > LEN_W) ? PW : LEN_W) + 2;
	localparam logic [PW:0]   POOL_P = (PW+1)'(POOL_BYTES);
	localparam logic [PW-1:0] ONE    = PW'(1);
	localparam logic [PW-1:0] HDR    = PW'(HEADER_BYTES);
	localparam logic [PW-1:0] HDR1   = PW'(HEADER_BYTES + 1);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_HDR_WR  = 5'b00010,
		ST_HDR_RD1 = 5'b00100,
		ST_HDR_RD2 = 5'b01000,
		ST_RD_DATA = 5'b10000
	} state_t;

	// modular add, n below the pool size
	function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] p, input logic [PW-1:0] n);
		logic [PW:0] t;
		t = {1'b0, p} + {1'b0, n};
		if (t >= POOL_P) begin
			t = t - POOL_P;
		end
		return t[PW-1:0];
	endfunction

	// bytes from r up to c around the ring
	function automatic logic [PW-1:0] ring_dist(input logic [PW-1:0] c, input logic [PW-1:0] r);
		logic [PW:0] t;
		if (c >= r) begin
			t = {1'b0, c} - {1'b0, r};
		end else begin
			t = {1'b0, c} + POOL_P - {1'b0, r};
		end
		return t[PW-1:0];
	endfunction

	state_t            state_q, state_d;
	logic [PW-1:0]     cwp_q, cwp_d;
	logic [PW-1:0]     swp_q, swp_d;
	logic [PW-1:0]     rp_q, rp_d;
	logic [LEN_W-1:0]  sleft_q, sleft_d;
	logic              sip_q, sip_d;
	logic [LEN_W-1:0]  rleft_q, rleft_d;
	logic [LEN_W-1:0]  rml_q, rml_d;
	logic              rip_q, rip_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic              first_q, first_d;
	logic              last_q, last_d;
	logic [BYTE_W-1:0] hb0_q;
	logic              accept;
	logic [NW-1:0]     need;
	logic              fits;
	logic [LEN_W-1:0]  hdr_len;

	assign in_ready = (state_q == ST_IDLE) && room;
	assign accept   = in_valid && in_ready;

	// room check keeps one byte free
	assign need = NW'(ring_dist(cwp_q, rp_q)) + NW'(HEADER_BYTES) + NW'(message_length);
	assign fits = need < NW'(POOL_BYTES);

	assign hdr_len = {mem_rdata[LEN_W-BYTE_W-1:0], hb0_q};

	always_comb begin
		state_d   = state_q;
		cwp_d     = cwp_q;
		swp_d     = swp_q;
		rp_d      = rp_q;
		sleft_d   = sleft_q;
		sip_d     = sip_q;
		rleft_d   = rleft_q;
		rml_d     = rml_q;
		rip_d     = rip_q;
		len_d     = len_q;
		first_d   = first_q;
		last_d    = last_q;
		res_valid = 1'b0;
		res       = '0;
		mem_we    = 1'b0;
		mem_waddr = swp_q;
		mem_wdata = '0;
		mem_raddr = rp_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_SEND_START: begin
							sip_d   = 1'b0;
							sleft_d = '0;
							swp_d   = cwp_q;
							if (fits) begin
								mem_we    = 1'b1;
								mem_waddr = cwp_q;
								mem_wdata = message_length[BYTE_W-1:0];
								len_d     = message_length;
								state_d   = ST_HDR_WR;
							end else begin
								res_valid = 1'b1;
							end
						end
						OP_SEND_BYTE: begin
							res_valid = 1'b1;
							if (sip_q) begin
								res.accepted = 1'b1;
								mem_we       = 1'b1;
								mem_waddr    = swp_q;
								mem_wdata    = payload_byte;
								swp_d        = ring_add(swp_q, ONE);
								sleft_d      = sleft_q - LEN_W'(1);
								if (sleft_q == LEN_W'(1)) begin
									cwp_d = ring_add(swp_q, ONE);
									sip_d = 1'b0;
								end
							end
						end
						OP_RECV: begin
							if (rip_q) begin
								mem_raddr = rp_q;
								rp_d      = ring_add(rp_q, ONE);
								rleft_d   = rleft_q - LEN_W'(1);
								first_d   = 1'b0;
								last_d    = (rleft_q == LEN_W'(1));
								if (rleft_q == LEN_W'(1)) begin
									rip_d = 1'b0;
								end
								state_d   = ST_RD_DATA;
							end else if (rp_q != cwp_q) begin
								mem_raddr = rp_q;
								state_d   = ST_HDR_RD1;
							end else begin
								res_valid = 1'b1;
							end
						end
						default: begin
							res_valid = 1'b1;
						end
					endcase
				end
			end
			ST_HDR_WR: begin
				mem_we       = 1'b1;
				mem_waddr    = ring_add(cwp_q, ONE);
				mem_wdata    = BYTE_W'(len_q[LEN_W-1:BYTE_W]);
				swp_d        = ring_add(cwp_q, HDR);
				if (len_q == '0) begin
					cwp_d = ring_add(cwp_q, HDR);
				end else begin
					sleft_d = len_q;
					sip_d   = 1'b1;
				end
				res_valid    = 1'b1;
				res.accepted = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_HDR_RD1: begin
				mem_raddr = ring_add(rp_q, ONE);
				state_d   = ST_HDR_RD2;
			end
			ST_HDR_RD2: begin
				if (hdr_len == '0) begin
					rp_d                 = ring_add(rp_q, HDR);
					res_valid            = 1'b1;
					res.accepted         = 1'b1;
					res.first_of_message = 1'b1;
					res.last_of_message  = 1'b1;
					state_d              = ST_IDLE;
				end else begin
					mem_raddr = ring_add(rp_q, HDR);
					rp_d      = ring_add(rp_q, HDR1);
					rleft_d   = hdr_len - LEN_W'(1);
					rml_d     = hdr_len;
					first_d   = 1'b1;
					last_d    = (hdr_len == LEN_W'(1));
					rip_d     = (hdr_len != LEN_W'(1));
					state_d   = ST_RD_DATA;
				end
			end
			ST_RD_DATA: begin
				res_valid            = 1'b1;
				res.accepted         = 1'b1;
				res.data_byte        = mem_rdata;
				res.first_of_message = first_q;
				res.last_of_message  = last_q;
				res.received_length  = rml_q;
				state_d              = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		res.fill_level = FILL_W'(ring_dist(cwp_d, rp_d));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cwp_q   <= '0;
			swp_q   <= '0;
			rp_q    <= '0;
			sleft_q <= '0;
			sip_q   <= 1'b0;
			rleft_q <= '0;
			rml_q   <= '0;
			rip_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cwp_q   <= cwp_d;
			swp_q   <= swp_d;
			rp_q    <= rp_d;
			sleft_q <= sleft_d;
			sip_q   <= sip_d;
			rleft_q <= rleft_d;
			rml_q   <= rml_d;
			rip_q   <= rip_d;
		end
	end

	always_ff @(posedge clk) begin
		len_q   <= len_d;
		first_q <= first_d;
		last_q  <= last_d;
		if (state_q == ST_HDR_RD1) begin
			hb0_q <= mem_rdata;
		end
	end

endmodule

`default_nettype wire

/* sv/mrf_checker.sv */
// port-level checks on the result stream of the message ring fifo
`default_nettype none

module mrf_checker
	import mrf_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic                 m_tlast,
	input wire logic [M_TUSER_W-1:0] m_tuser
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_word_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_refused_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[21:0] == 22'd0) && !m_tuser[1] && !m_tlast)
		else $error("refused word carries receive data or marks");

	a_marks_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1] || m_tlast) |-> m_tuser[0])
		else $error("message mark on a refused word");

endmodule

bind message_ring_fifo_unit mrf_checker u_mrf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

`default_nettype wire

/* dv/tb.sv */
// self-checking testbench for the message ring fifo unit
`timescale 1ns / 1ps

module tb;
	import mrf_pkg::*;

	localparam int unsigned POOL = POOL_BYTES_DEF;
	localparam int unsigned HDR  = HEADER_BYTES_DEF;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned WORDS_PER_PHASE = 458;
	localparam int unsigned PRINT_CAP = 100;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] pb;
		logic [LEN_W-1:0]  len;
		bit                typed;
		res_t              want;
	} stim_row_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [S_TUSER_W-1:0] s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tlast;
	logic [M_TUSER_W-1:0] m_tuser;

	message_ring_fifo_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow ring state
	logic [BYTE_W-1:0] ring_copy [0:POOL-1];
	logic [FILL_W-1:0] commit_ptr  = '0;
	logic [FILL_W-1:0] stage_ptr   = '0;
	logic [FILL_W-1:0] rd_ptr      = '0;
	logic [LEN_W-1:0]  send_left   = '0;
	logic [LEN_W-1:0]  recv_left   = '0;
	logic [LEN_W-1:0]  recv_len    = '0;
	logic              send_active = 1'b0;
	logic              recv_active = 1'b0;

	res_t        pending_results [$];
	res_t        front_result;
	stim_row_t   plan [$];
	int unsigned mismatches = 0;
	int unsigned words_sent = 0;
	int unsigned idle_pct   = 0;
	int unsigned stall_pct  = 0;

	function automatic logic [FILL_W-1:0] held_bytes();
		return commit_ptr - rd_ptr;
	endfunction

	function automatic res_t res_of(bit acc, logic [BYTE_W-1:0] data, bit first, bit last,
			logic [LEN_W-1:0] rlen, logic [FILL_W-1:0] fill);
		res_t r;
		r.accepted         = acc;
		r.data_byte        = data;
		r.first_of_message = first;
		r.last_of_message  = last;
		r.received_length  = rlen;
		r.fill_level       = fill;
		return r;
	endfunction

	// advance the shadow ring by one word and give the result it should produce
	task automatic ring_step(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] pb,
			input logic [LEN_W-1:0] len, output res_t r);
		int unsigned room_need;
		logic [LEN_W-1:0] hdr_len;
		r = '0;
		case (op)
			OP_SEND_START: begin
				// any unfinished message is dropped first
				send_active = 1'b0;
				send_left   = '0;
				stage_ptr   = commit_ptr;
				room_need   = int'(held_bytes()) + HDR + int'(len);
				if (room_need < POOL) begin
					for (int k = 0; k < HDR; k++) begin
						ring_copy[stage_ptr] = (k == 0) ? len[7:0] :
							(k == 1) ? {2'b00, len[13:8]} : 8'h00;
						stage_ptr++;
					end
					r.accepted = 1'b1;
					if (len == 0) begin
						commit_ptr = stage_ptr;
					end else begin
						send_left   = len;
						send_active = 1'b1;
					end
				end
			end
			OP_SEND_BYTE: begin
				if (send_active) begin
					ring_copy[stage_ptr] = pb;
					stage_ptr++;
					send_left--;
					if (send_left == 0) begin
						commit_ptr  = stage_ptr;
						send_active = 1'b0;
					end
					r.accepted = 1'b1;
				end
			end
			OP_RECV: begin
				if (recv_active) begin
					r.accepted  = 1'b1;
					r.data_byte = ring_copy[rd_ptr];
					rd_ptr++;
					recv_left--;
					r.received_length = recv_len;
					if (recv_left == 0) begin
						r.last_of_message = 1'b1;
						recv_active       = 1'b0;
					end
				end else if (rd_ptr != commit_ptr) begin
					hdr_len = '0;
					for (int k = 0; k < HDR; k++) begin
						if (k == 0)
							hdr_len[7:0] = ring_copy[rd_ptr];
						else if (k == 1)
							hdr_len[13:8] = ring_copy[rd_ptr][5:0];
						rd_ptr++;
					end
					r.accepted         = 1'b1;
					r.first_of_message = 1'b1;
					r.received_length  = hdr_len;
					if (hdr_len == 0) begin
						r.last_of_message = 1'b1;
					end else begin
						r.data_byte = ring_copy[rd_ptr];
						rd_ptr++;
						recv_left = hdr_len - 1'b1;
						recv_len  = hdr_len;
						if (recv_left == 0)
							r.last_of_message = 1'b1;
						else
							recv_active = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		r.fill_level = held_bytes();
	endtask

	// present one word, hold it until taken, then log what it should return
	task automatic drive_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] pb,
			input logic [LEN_W-1:0] len);
		res_t predicted;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, len, pb};
		do @(posedge clk); while (!s_tready);
		ring_step(op, pb, len, predicted);
		pending_results.push_back(predicted);
		words_sent++;
	endtask

	// mostly short messages, a few mid-size, rarely anything at all
	function automatic logic [LEN_W-1:0] pick_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return $urandom_range(0, 8);
		else if (roll < 90)
			return $urandom_range(9, 64);
		else if (roll < 98)
			return $urandom_range(65, 400);
		return $urandom_range(0, (1 << LEN_W) - 1);
	endfunction

	task automatic random_word();
		int unsigned roll;
		logic [BYTE_W-1:0] pb;
		logic [LEN_W-1:0] noise_len;
		roll      = $urandom_range(0, 99);
		pb        = $urandom_range(0, 255);
		noise_len = $urandom_range(0, (1 << LEN_W) - 1);
		if (send_active) begin
			if (roll < 58)
				drive_word(OP_SEND_BYTE, pb, noise_len);
			else if (roll < 93)
				drive_word(OP_RECV, pb, noise_len);
			else if (roll < 97)
				drive_word(OP_SEND_START, pb, pick_length());
			else
				drive_word(OP_UNUSED, pb, noise_len);
		end else begin
			if (roll < 40)
				drive_word(OP_SEND_START, pb, pick_length());
			else if (roll < 88)
				drive_word(OP_RECV, pb, noise_len);
			else if (roll < 95)
				drive_word(OP_SEND_BYTE, pb, noise_len);
			else
				drive_word(OP_UNUSED, pb, noise_len);
		end
	endtask

	// one committed message, then a start one byte too long and the exact fit
	// that leaves one byte free; the staged fit is dropped by an empty message
	task automatic room_edge_once();
		int unsigned body;
		int unsigned tail;
		while (send_active)
			drive_word(OP_SEND_BYTE, $urandom_range(0, 255), '0);
		while (recv_active || rd_ptr != commit_ptr)
			drive_word(OP_RECV, '0, '0);
		body = $urandom_range(20, 60);
		drive_word(OP_SEND_START, '0, LEN_W'(body));
		repeat (body)
			drive_word(OP_SEND_BYTE, $urandom_range(0, 255), $urandom_range(0, 16383));
		drive_word(OP_SEND_START, '0, LEN_W'((POOL - HDR) - held_bytes()));
		tail = (POOL - HDR - 1) - held_bytes();
		drive_word(OP_SEND_START, '0, LEN_W'(tail));
		repeat (4)
			drive_word(OP_SEND_BYTE, $urandom_range(0, 255), '0);
		drive_word(OP_SEND_START, '0, '0);
		while (recv_active || rd_ptr != commit_ptr)
			drive_word(OP_RECV, $urandom_range(0, 255), $urandom_range(0, 16383));
	endtask

	task automatic random_phase();
		int unsigned base;
		base = words_sent;
		while (words_sent - base < WORDS_PER_PHASE)
			random_word();
	endtask

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		if (mismatches < PRINT_CAP)
			$display("%0t ns: result %s got %0h want %0h", $time, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= stall_pct);

	// result checker: every taken word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("word with nothing pending", m_tdata, 0);
			end else begin
				front_result = pending_results.pop_front();
				if (m_tuser[0] !== front_result.accepted)
					report_mismatch("accepted", m_tuser[0], front_result.accepted);
				if (m_tdata[7:0] !== front_result.data_byte)
					report_mismatch("data_byte", m_tdata[7:0], front_result.data_byte);
				if (m_tuser[1] !== front_result.first_of_message)
					report_mismatch("first_of_message", m_tuser[1],
						front_result.first_of_message);
				if (m_tlast !== front_result.last_of_message)
					report_mismatch("last_of_message", m_tlast,
						front_result.last_of_message);
				if (m_tdata[21:8] !== front_result.received_length)
					report_mismatch("received_length", m_tdata[21:8],
						front_result.received_length);
				if (m_tdata[35:22] !== front_result.fill_level)
					report_mismatch("fill_level", m_tdata[35:22], front_result.fill_level);
			end
		end
	end

	initial begin
		// op, payload byte, length, typed, typed result
		plan.push_back('{OP_RECV,       8'h00, 14'd0,     1'b1, res_of(0, 8'h00, 0, 0, 0, 0)});
		plan.push_back('{OP_SEND_BYTE,  8'h00, 14'd0,     1'b1, res_of(0, 8'h00, 0, 0, 0, 0)});
		plan.push_back('{OP_UNUSED,     8'hff, 14'h3fff,  1'b1, res_of(0, 8'h00, 0, 0, 0, 0)});
		plan.push_back('{OP_SEND_START, 8'h00, 14'd16376, 1'b1, res_of(0, 8'h00, 0, 0, 0, 0)});
		plan.push_back('{OP_SEND_START, 8'hff, 14'd16383, 1'b1, res_of(0, 8'h00, 0, 0, 0, 0)});
		plan.push_back('{OP_SEND_START, 8'h00, 14'd16375, 1'b1, res_of(1, 8'h00, 0, 0, 0, 0)});
		plan.push_back('{OP_SEND_BYTE,  8'hff, 14'd0,     1'b1, res_of(1, 8'h00, 0, 0, 0, 0)});
		// restart mid-message with an empty message, committed at once
		plan.push_back('{OP_SEND_START, 8'h00, 14'd0,     1'b1, res_of(1, 8'h00, 0, 0, 0, 8)});
		plan.push_back('{OP_SEND_START, 8'h00, 14'd1,     1'b1, res_of(1, 8'h00, 0, 0, 0, 8)});
		plan.push_back('{OP_SEND_BYTE,  8'h81, 14'd0,     1'b1, res_of(1, 8'h00, 0, 0, 0, 17)});
		plan.push_back('{OP_RECV,       8'h00, 14'd0,     1'b1, res_of(1, 8'h00, 1, 1, 0, 9)});
		plan.push_back('{OP_RECV,       8'h00, 14'd0,     1'b1, res_of(1, 8'h81, 1, 1, 1, 0)});
		plan.push_back('{OP_RECV,       8'h00, 14'd0,     1'b1, res_of(0, 8'h00, 0, 0, 0, 0)});
		plan.push_back('{OP_SEND_START, 8'h00, 14'd3,     1'b1, res_of(1, 8'h00, 0, 0, 0, 0)});
		plan.push_back('{OP_SEND_BYTE,  8'ha5, 14'd0,     1'b0, '0});
		plan.push_back('{OP_SEND_BYTE,  8'h5a, 14'd0,     1'b0, '0});
		plan.push_back('{OP_SEND_BYTE,  8'h3c, 14'd0,     1'b0, '0});
		plan.push_back('{OP_SEND_BYTE,  8'h77, 14'd0,     1'b1, res_of(0, 8'h00, 0, 0, 0, 11)});
		plan.push_back('{OP_RECV,       8'h00, 14'd0,     1'b1, res_of(1, 8'ha5, 1, 0, 3, 2)});
		plan.push_back('{OP_SEND_START, 8'h00, 14'd8192,  1'b1, res_of(1, 8'h00, 0, 0, 0, 2)});
		plan.push_back('{OP_RECV,       8'h00, 14'd0,     1'b1, res_of(1, 8'h5a, 0, 0, 3, 1)});
		plan.push_back('{OP_RECV,       8'h00, 14'd0,     1'b1, res_of(1, 8'h3c, 0, 1, 3, 0)});
		// a staged message stays invisible
		plan.push_back('{OP_RECV,       8'h00, 14'd0,     1'b1, res_of(0, 8'h00, 0, 0, 0, 0)});
		plan.push_back('{OP_UNUSED,     8'h00, 14'd0,     1'b1, res_of(0, 8'h00, 0, 0, 0, 0)});
		plan.push_back('{OP_SEND_START, 8'h00, 14'd2,     1'b1, res_of(1, 8'h00, 0, 0, 0, 0)});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			drive_word(plan[i].op, plan[i].pb, plan[i].len);
			if (plan[i].typed)
				pending_results[$] = plan[i].want;
		end

		room_edge_once();
		random_phase();

		idle_pct  = 82;
		stall_pct = 0;
		random_phase();

		idle_pct  = 0;
		stall_pct = 82;
		random_phase();

		idle_pct  = 38;
		stall_pct = 38;
		random_phase();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// hang guard
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
